/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of the I2C byte engine.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property checked on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("i2cmbe assertion failed");

// Condition that must never hold on a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("i2cmbe forbidden condition seen");

`endif

/* rtl/i2cmbe_pkg.sv */
// Shared types and codes of the I2C master byte engine.
// Depends on nothing; imported by the engine, the top level and the checker.
package i2cmbe_pkg;

   // Command codes carried by a command word.
   localparam logic [2:0] CMD_START     = 3'd0;
   localparam logic [2:0] CMD_STOP      = 3'd1;
   localparam logic [2:0] CMD_WRITE     = 3'd2;
   localparam logic [2:0] CMD_READ_ACK  = 3'd3;
   localparam logic [2:0] CMD_READ_NACK = 3'd4;

   // Status codes returned with each result word.
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_NACK    = 2'd1;
   localparam logic [1:0] STAT_TIMEOUT = 2'd2;
   localparam logic [1:0] STAT_REJECT  = 2'd3;

   // Configuration register indexes and reset values.
   localparam logic CSR_PHASE_DELAY   = 1'b0;
   localparam logic CSR_START_TIMEOUT = 1'b1;
   localparam logic [7:0]  PHASE_DELAY_RESET   = 8'd4;
   localparam logic [15:0] START_TIMEOUT_RESET = 16'd1000;

   // Input word as held in the input register.
   typedef struct packed {
      logic       kind;
      logic [2:0] command;
      logic [7:0] wdata;
      logic       sda_in;
      logic       scl_in;
   } item_type;

   // Live configuration seen by the engine.
   typedef struct packed {
      logic [7:0]  phase_delay;
      logic [15:0] start_timeout;
   } cfg_type;

   // Result word as held in the output register.
   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       done_res;
      logic [1:0] status;
      logic [7:0] rdata;
      logic       ready_res;
   } result_type;

endpackage

/* rtl/i2cmbe_engine.sv */
// Byte-level I2C pin sequencer: holds the operation state and computes the
// result of one word per step. Depends on i2cmbe_pkg.
module i2cmbe_engine
   import i2cmbe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   // Running operation, one-hot.
   typedef enum logic [4:0] {
      OP_IDLE  = 5'b00001,
      OP_START = 5'b00010,
      OP_STOP  = 5'b00100,
      OP_WRITE = 5'b01000,
      OP_READ  = 5'b10000
   } op_type;

   // Phase numbers within an operation.
   localparam logic [3:0] PH0 = 4'd0;
   localparam logic [3:0] PH1 = 4'd1;
   localparam logic [3:0] PH2 = 4'd2;
   localparam logic [3:0] PH3 = 4'd3;
   localparam logic [3:0] PH4 = 4'd4;

   // Line drive codes, {scl, sda}; 1 means released.
   localparam logic [1:0] DRV_BOTH_HIGH = 2'b11;
   localparam logic [1:0] DRV_SCL_HIGH  = 2'b10;
   localparam logic [1:0] DRV_SDA_HIGH  = 2'b01;
   localparam logic [1:0] DRV_BOTH_LOW  = 2'b00;

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   op_type      op_ff,    op_in;
   logic        nack_ff,  nack_in;
   logic [3:0]  phase_ff, phase_in;
   logic [3:0]  bit_ff,   bit_in;
   logic [7:0]  delay_ff, delay_in;
   logic [15:0] wait_ff,  wait_in;
   logic [7:0]  shift_ff, shift_in;
   logic [1:0]  drive_ff, drive_in;
   logic [7:0]  read_ff,  read_in;

   logic [8:0]  dly_sum;
   logic        ph_end;
   logic [7:0]  dly_next;
   logic [3:0]  bit_plus;
   logic        wbit;
   logic        abit;
   logic        done;
   logic [1:0]  status;

   // Phase hold counter: a phase ends on its phase_delay-th tick; zero acts as one.
   assign dly_sum  = {1'b0, delay_ff} + 9'd1;
   assign ph_end   = dly_sum >= {1'b0, cfg.phase_delay};
   assign dly_next = ph_end ? 8'd0 : dly_sum[7:0];
   assign bit_plus = bit_ff + 4'd1;
   assign wbit     = shift_ff[7];
   assign abit     = nack_ff;

   // Next state and result of the word in the input register.
   always_comb begin
      op_in    = op_ff;
      nack_in  = nack_ff;
      phase_in = phase_ff;
      bit_in   = bit_ff;
      delay_in = delay_ff;
      wait_in  = wait_ff;
      shift_in = shift_ff;
      drive_in = drive_ff;
      read_in  = read_ff;
      done     = 1'b0;
      status   = STAT_OK;

      if (item.kind) begin
         // Commands start an operation only when idle and the code is known.
         if (op_ff != OP_IDLE || !(item.command inside {CMD_START, CMD_STOP, CMD_WRITE,
                                                        CMD_READ_ACK, CMD_READ_NACK})) begin
            status = STAT_REJECT;
         end else begin
            case (item.command)
               CMD_START: op_in = OP_START;
               CMD_STOP:  op_in = OP_STOP;
               CMD_WRITE: op_in = OP_WRITE;
               default:   op_in = OP_READ;
            endcase
            nack_in  = item.command == CMD_READ_NACK;
            phase_in = PH0;
            bit_in   = 4'd0;
            delay_in = 8'd0;
            wait_in  = 16'd0;
            shift_in = (item.command == CMD_WRITE) ? item.wdata : 8'd0;
         end
      end else begin
         case (op_ff)
            OP_START: begin
               if (phase_ff == PH0) begin
                  // Wait for an idle bus, counting busy ticks.
                  drive_in = DRV_BOTH_HIGH;
                  if (item.sda_in && item.scl_in) begin
                     phase_in = PH1;
                     delay_in = 8'd0;
                  end else if (wait_ff >= cfg.start_timeout) begin
                     done   = 1'b1;
                     status = STAT_TIMEOUT;
                  end else begin
                     wait_in = wait_ff + 16'd1;
                  end
               end else if (phase_ff == PH1) begin
                  drive_in = DRV_BOTH_HIGH;
                  delay_in = dly_next;
                  if (ph_end) phase_in = PH2;
               end else if (phase_ff == PH2) begin
                  drive_in = DRV_SCL_HIGH;
                  delay_in = dly_next;
                  if (ph_end) phase_in = PH3;
               end else begin
                  drive_in = DRV_BOTH_LOW;
                  delay_in = dly_next;
                  done     = ph_end;
               end
            end
            OP_STOP: begin
               delay_in = dly_next;
               if (phase_ff == PH0) begin
                  drive_in = DRV_BOTH_LOW;
                  if (ph_end) phase_in = PH1;
               end else if (phase_ff == PH1) begin
                  drive_in = DRV_SCL_HIGH;
                  if (ph_end) phase_in = PH2;
               end else begin
                  drive_in = DRV_BOTH_HIGH;
                  done     = ph_end;
               end
            end
            OP_WRITE: begin
               delay_in = dly_next;
               if (phase_ff == PH0) begin
                  drive_in = {1'b0, wbit};
                  if (ph_end) phase_in = PH1;
               end else if (phase_ff == PH1) begin
                  drive_in = {1'b1, wbit};
                  if (ph_end) begin
                     shift_in = {shift_ff[6:0], 1'b0};
                     bit_in   = bit_plus;
                     phase_in = (bit_plus >= BITS_PER_BYTE) ? PH2 : PH0;
                  end
               end else if (phase_ff == PH2) begin
                  drive_in = DRV_SDA_HIGH;
                  if (ph_end) phase_in = PH3;
               end else if (phase_ff == PH3) begin
                  // Acknowledge bit is sampled on the last tick of the high phase.
                  drive_in = DRV_BOTH_HIGH;
                  if (ph_end) begin
                     shift_in = {7'd0, item.sda_in};
                     phase_in = PH4;
                  end
               end else begin
                  drive_in = DRV_SDA_HIGH;
                  done     = ph_end;
                  status   = (ph_end && shift_ff[0]) ? STAT_NACK : STAT_OK;
               end
            end
            OP_READ: begin
               delay_in = dly_next;
               if (phase_ff == PH0) begin
                  drive_in = DRV_SDA_HIGH;
                  if (ph_end) phase_in = PH1;
               end else if (phase_ff == PH1) begin
                  drive_in = DRV_BOTH_HIGH;
                  if (ph_end) begin
                     shift_in = {shift_ff[6:0], item.sda_in};
                     bit_in   = bit_plus;
                     if (bit_plus >= BITS_PER_BYTE) begin
                        read_in  = {shift_ff[6:0], item.sda_in};
                        phase_in = PH2;
                     end else begin
                        phase_in = PH0;
                     end
                  end
               end else if (phase_ff == PH2) begin
                  drive_in = DRV_SDA_HIGH;
                  if (ph_end) phase_in = PH3;
               end else if (phase_ff == PH3) begin
                  drive_in = {1'b0, abit};
                  if (ph_end) phase_in = PH4;
               end else if (phase_ff == PH4) begin
                  drive_in = {1'b1, abit};
                  if (ph_end) phase_in = PH4 + 4'd1;
               end else begin
                  drive_in = {1'b0, abit};
                  done     = ph_end;
               end
            end
            default: begin
               // Idle ticks leave everything as it is.
            end
         endcase

         // A finished operation returns to idle with its phase, bit and delay counters cleared.
         if (done) begin
            op_in    = OP_IDLE;
            phase_in = PH0;
            bit_in   = 4'd0;
            delay_in = 8'd0;
         end
      end
   end

   // Result reflects the state after this word.
   assign result.scl_out   = drive_in[1];
   assign result.sda_out   = drive_in[0];
   assign result.done_res  = done;
   assign result.status    = status;
   assign result.rdata     = read_in;
   assign result.ready_res = op_in == OP_IDLE;

   // Operation state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff    <= OP_IDLE;
         nack_ff  <= 1'b0;
         phase_ff <= PH0;
         bit_ff   <= 4'd0;
         delay_ff <= 8'd0;
         wait_ff  <= 16'd0;
         shift_ff <= 8'd0;
         drive_ff <= DRV_BOTH_HIGH;
         read_ff  <= 8'd0;
      end else if (step) begin
         op_ff    <= op_in;
         nack_ff  <= nack_in;
         phase_ff <= phase_in;
         bit_ff   <= bit_in;
         delay_ff <= delay_in;
         wait_ff  <= wait_in;
         shift_ff <= shift_in;
         drive_ff <= drive_in;
         read_ff  <= read_in;
      end
   end

endmodule

/* rtl/i2c_master_byte_engine_core.sv */
// Top level of the I2C master byte engine: input register, engine, result register
// and configuration registers. Depends on i2cmbe_pkg and i2cmbe_engine.
//
//   Channel  Direction  Handshake            Contents
//   req      in         req_valid/req_ready  tick or command word
//   rsp      out        rsp_valid/rsp_ready  pin drive, done, status, read byte, ready
//   csr      in         csr_we               phase_delay (0), start_timeout (1)
//
// One word per clock cycle while the result port is not stalled; a word passes from
// the input register to the result register and is then offered at the result port.
// Every word gives exactly one result word.
// A stalled result holds the result register; the input register keeps accepting
// until it is full as well. Reset is synchronous.
module i2c_master_byte_engine_core
   import i2cmbe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [2:0]  req_command,
   input  logic [7:0]  req_wdata,
   input  logic        req_sda_in,
   input  logic        req_scl_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_scl_out,
   output logic        rsp_sda_out,
   output logic        rsp_done_res,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_rdata,
   output logic        rsp_ready_res,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   logic       in_valid_ff;
   item_type   in_item_ff;
   logic       rsp_valid_ff;
   result_type rsp_ff;
   cfg_type    cfg_ff;
   result_type eng_result;
   logic       out_free;
   logic       step;

   // The word in the input register moves on when the result register can take it.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || step;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff.kind    <= req_kind;
         in_item_ff.command <= req_command;
         in_item_ff.wdata   <= req_wdata;
         in_item_ff.sda_in  <= req_sda_in;
         in_item_ff.scl_in  <= req_scl_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_delay   <= PHASE_DELAY_RESET;
         cfg_ff.start_timeout <= START_TIMEOUT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PHASE_DELAY:   cfg_ff.phase_delay   <= csr_wdata[7:0];
            CSR_START_TIMEOUT: cfg_ff.start_timeout <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   i2cmbe_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_item_ff),
      .cfg    (cfg_ff),
      .result (eng_result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= eng_result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_scl_out   = rsp_ff.scl_out;
   assign rsp_sda_out   = rsp_ff.sda_out;
   assign rsp_done_res  = rsp_ff.done_res;
   assign rsp_status    = rsp_ff.status;
   assign rsp_rdata     = rsp_ff.rdata;
   assign rsp_ready_res = rsp_ff.ready_res;

endmodule

/* rtl/i2cmbe_checker.sv */
// Port-level checks of the I2C master byte engine, bound to the top level.
// Depends on i2cmbe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module i2cmbe_checker
   import i2cmbe_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_scl_out,
   input logic       rsp_sda_out,
   input logic       rsp_done_res,
   input logic [1:0] rsp_status,
   input logic [7:0] rsp_rdata,
   input logic       rsp_ready_res
);

   // A stalled result word stays put.
   `ASSERT_CLK(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable({rsp_scl_out, rsp_sda_out, rsp_done_res, rsp_status, rsp_rdata, rsp_ready_res})))

   // A finished operation leaves the engine idle.
   `ASSERT_CLK(a_done_idle, clock, reset, (rsp_valid && rsp_done_res) |-> rsp_ready_res)

   // NACK and timeout are only reported when an operation finishes.
   `ASSERT_CLK(a_err_done, clock, reset, (rsp_valid && (rsp_status == STAT_NACK || rsp_status == STAT_TIMEOUT)) |-> rsp_done_res)

   // A timed-out start leaves both lines released.
   `ASSERT_NEVER(a_timeout_lines, clock, reset, rsp_valid && rsp_status == STAT_TIMEOUT && !(rsp_scl_out && rsp_sda_out))

endmodule

bind i2c_master_byte_engine_core i2cmbe_checker u_i2cmbe_checker (.*);

/* dv/i2c_master_byte_engine_core_tb.sv */
// Self-checking testbench for the I2C master byte engine top level.
// Depends on i2cmbe_pkg and i2c_master_byte_engine_core; a scoreboard class tracks
// the engine's pin sequence and checks every result word in order.
`timescale 1ns / 1ps

import i2cmbe_pkg::*;

// Operation code that marks the engine as idle.
localparam logic [2:0] OP_IDLE = 3'd7;

// Line drive patterns as {scl, sda}; a 1 releases the line.
localparam logic [1:0] PINS_LOW      = 2'b00;
localparam logic [1:0] PINS_SDA_HIGH = 2'b01;
localparam logic [1:0] PINS_SCL_HIGH = 2'b10;
localparam logic [1:0] PINS_RELEASED = 2'b11;

// Tracks the engine state word by word and holds the result words still owed.
class engine_scoreboard;
   logic [7:0]  phase_delay;
   logic [15:0] start_timeout;
   logic [2:0]  op_code;
   logic [3:0]  phase;
   logic [3:0]  bit_count;
   logic [7:0]  delay_count;
   logic [15:0] wait_count;
   logic [7:0]  shift_reg;
   logic [1:0]  pins;
   logic [7:0]  read_byte;
   logic        op_done;
   logic [1:0]  op_status;
   result_type  pending_results[$];
   int unsigned error_count;
   int unsigned checked_count;

   function new();
      phase_delay   = PHASE_DELAY_RESET;
      start_timeout = START_TIMEOUT_RESET;
      op_code       = OP_IDLE;
      phase         = '0;
      bit_count     = '0;
      delay_count   = '0;
      wait_count    = '0;
      shift_reg     = '0;
      pins          = PINS_RELEASED;
      read_byte     = '0;
      op_done       = 1'b0;
      op_status     = STAT_OK;
      error_count   = 0;
      checked_count = 0;
   endfunction

   function void set_register(logic index, logic [15:0] value);
      if (index == CSR_PHASE_DELAY) begin
         phase_delay = value[7:0];
      end else begin
         start_timeout = value;
      end
   endfunction

   // Drives the lines for one tick of a phase; true once the phase has run out.
   // A zero delay ends every phase after one tick, the same as a delay of one.
   function bit hold_phase(logic [1:0] drive);
      pins = drive;
      delay_count = delay_count + 8'd1;
      if (delay_count >= phase_delay) begin
         delay_count = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function void end_operation(logic [1:0] st);
      op_done     = 1'b1;
      op_status   = st;
      op_code     = OP_IDLE;
      phase       = '0;
      bit_count   = '0;
      delay_count = '0;
   endfunction

   // Advances the running operation by one tick with the sampled line levels.
   function void advance_tick(logic sda, logic scl);
      logic b;
      case (op_code)
         CMD_START: begin
            if (phase == 0) begin
               // Wait for both lines high; busy ticks count toward the timeout.
               pins = PINS_RELEASED;
               if (sda && scl) begin
                  phase = 4'd1;
                  delay_count = '0;
               end else if (wait_count >= start_timeout) begin
                  end_operation(STAT_TIMEOUT);
               end else begin
                  wait_count = wait_count + 16'd1;
               end
            end else if (phase == 1) begin
               if (hold_phase(PINS_RELEASED)) phase = 4'd2;
            end else if (phase == 2) begin
               if (hold_phase(PINS_SCL_HIGH)) phase = 4'd3;
            end else begin
               if (hold_phase(PINS_LOW)) end_operation(STAT_OK);
            end
         end
         CMD_STOP: begin
            if (phase == 0) begin
               if (hold_phase(PINS_LOW)) phase = 4'd1;
            end else if (phase == 1) begin
               if (hold_phase(PINS_SCL_HIGH)) phase = 4'd2;
            end else begin
               if (hold_phase(PINS_RELEASED)) end_operation(STAT_OK);
            end
         end
         CMD_WRITE: begin
            b = shift_reg[7];
            if (phase == 0) begin
               if (hold_phase({1'b0, b})) phase = 4'd1;
            end else if (phase == 1) begin
               if (hold_phase({1'b1, b})) begin
                  shift_reg = shift_reg << 1;
                  bit_count = bit_count + 4'd1;
                  phase = (bit_count >= 8) ? 4'd2 : 4'd0;
               end
            end else if (phase == 2) begin
               if (hold_phase(PINS_SDA_HIGH)) phase = 4'd3;
            end else if (phase == 3) begin
               // The acknowledge is sampled on the last tick of the high clock.
               if (hold_phase(PINS_RELEASED)) begin
                  shift_reg = {7'd0, sda};
                  phase = 4'd4;
               end
            end else begin
               if (hold_phase(PINS_SDA_HIGH))
                  end_operation(shift_reg[0] ? STAT_NACK : STAT_OK);
            end
         end
         CMD_READ_ACK, CMD_READ_NACK: begin
            b = (op_code == CMD_READ_NACK);
            if (phase == 0) begin
               if (hold_phase(PINS_SDA_HIGH)) phase = 4'd1;
            end else if (phase == 1) begin
               if (hold_phase(PINS_RELEASED)) begin
                  shift_reg = {shift_reg[6:0], sda};
                  bit_count = bit_count + 4'd1;
                  if (bit_count >= 8) begin
                     read_byte = shift_reg;
                     phase = 4'd2;
                  end else begin
                     phase = 4'd0;
                  end
               end
            end else if (phase == 2) begin
               if (hold_phase(PINS_SDA_HIGH)) phase = 4'd3;
            end else if (phase == 3) begin
               if (hold_phase({1'b0, b})) phase = 4'd4;
            end else if (phase == 4) begin
               if (hold_phase({1'b1, b})) phase = 4'd5;
            end else begin
               if (hold_phase({1'b0, b})) end_operation(STAT_OK);
            end
         end
         default: ;
      endcase
   endfunction

   // Notes an accepted input word and queues the result word it must produce.
   function void note_word(item_type w);
      result_type want;
      logic [1:0] st;
      op_done   = 1'b0;
      op_status = STAT_OK;
      st        = STAT_OK;
      if (w.kind) begin
         // Commands never move the pins; busy or unknown codes are rejected.
         if (op_code != OP_IDLE || w.command > CMD_READ_NACK) begin
            st = STAT_REJECT;
         end else begin
            op_code     = w.command;
            phase       = '0;
            bit_count   = '0;
            delay_count = '0;
            wait_count  = '0;
            shift_reg   = (w.command == CMD_WRITE) ? w.wdata : 8'h00;
         end
      end else begin
         advance_tick(w.sda_in, w.scl_in);
         if (op_done) st = op_status;
      end
      want.scl_out   = pins[1];
      want.sda_out   = pins[0];
      want.done_res  = op_done;
      want.status    = st;
      want.rdata     = read_byte;
      want.ready_res = (op_code == OP_IDLE);
      pending_results.push_back(want);
   endfunction

   function void match(string field, logic [7:0] want, logic [7:0] seen);
      if (want !== seen) begin
         $error("%s: expected %0d, got %0d", field, want, seen);
         error_count++;
      end
   endfunction

   // Compares an accepted result word with the oldest one still owed.
   function void check_word(result_type got);
      result_type want;
      checked_count++;
      if (pending_results.size() == 0) begin
         $error("result word arrived with nothing outstanding");
         error_count++;
         return;
      end
      want = pending_results.pop_front();
      match("scl_out", 8'(want.scl_out), 8'(got.scl_out));
      match("sda_out", 8'(want.sda_out), 8'(got.sda_out));
      match("done_res", 8'(want.done_res), 8'(got.done_res));
      match("status", 8'(want.status), 8'(got.status));
      match("rdata", want.rdata, got.rdata);
      match("ready_res", 8'(want.ready_res), 8'(got.ready_res));
   endfunction
endclass

module i2c_master_byte_engine_core_tb;

   localparam int unsigned STALL_LIMIT = 4000;
   localparam int unsigned LONG_HOLD   = 150;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_ready;
   logic        req_kind      = 1'b0;
   logic [2:0]  req_command   = '0;
   logic [7:0]  req_wdata     = '0;
   logic        req_sda_in    = 1'b1;
   logic        req_scl_in    = 1'b1;
   logic        rsp_valid;
   logic        rsp_ready     = 1'b0;
   logic        rsp_scl_out;
   logic        rsp_sda_out;
   logic        rsp_done_res;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_rdata;
   logic        rsp_ready_res;
   logic        csr_we        = 1'b0;
   logic        csr_index     = 1'b0;
   logic [15:0] csr_wdata     = '0;

   engine_scoreboard board = new();

   bit          sender_gaps_on    = 1'b0;
   bit          receiver_stalls_on = 1'b1;
   bit          long_hold_done    = 1'b0;
   int unsigned busy_ticks_left   = 0;
   int unsigned quiet_cycles      = 0;

   i2c_master_byte_engine_core u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_command   (req_command),
      .req_wdata     (req_wdata),
      .req_sda_in    (req_sda_in),
      .req_scl_in    (req_scl_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_scl_out   (rsp_scl_out),
      .rsp_sda_out   (rsp_sda_out),
      .rsp_done_res  (rsp_done_res),
      .rsp_status    (rsp_status),
      .rsp_rdata     (rsp_rdata),
      .rsp_ready_res (rsp_ready_res),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #5 clock = ~clock;

   // Gap lengths: mostly none, some short, a few long.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offers one word and returns at the edge where it is accepted.
   task automatic send_word(input item_type w);
      int unsigned gap;
      gap = sender_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= w.kind;
      req_command <= w.command;
      req_wdata   <= w.wdata;
      req_sda_in  <= w.sda_in;
      req_scl_in  <= w.scl_in;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_word(w);
   endtask

   task automatic send_tick(input logic sda, input logic scl);
      item_type w;
      w.kind    = 1'b0;
      w.command = 3'($urandom_range(0, 7));
      w.wdata   = 8'($urandom_range(0, 255));
      w.sda_in  = sda;
      w.scl_in  = scl;
      send_word(w);
   endtask

   task automatic send_command(input logic [2:0] cmd, input logic [7:0] data);
      item_type w;
      w.kind    = 1'b1;
      w.command = cmd;
      w.wdata   = data;
      w.sda_in  = 1'($urandom_range(0, 1));
      w.scl_in  = 1'($urandom_range(0, 1));
      send_word(w);
   endtask

   // Ticks the running operation to its end on a free bus.
   task automatic finish_running();
      busy_ticks_left = 0;
      while (board.op_code != OP_IDLE) begin
         if (board.op_code == CMD_START && board.phase == 0)
            send_tick(1'b1, 1'b1);
         else
            send_tick(1'($urandom_range(0, 1)), 1'b1);
      end
   endtask

   // Stops offering and waits until every owed result word has come back.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (board.pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_registers(input logic [7:0] delay, input logic [15:0] timeout);
      csr_we    <= 1'b1;
      csr_index <= CSR_PHASE_DELAY;
      csr_wdata <= {8'd0, delay};
      @(posedge clock);
      csr_index <= CSR_START_TIMEOUT;
      csr_wdata <= timeout;
      @(posedge clock);
      csr_we <= 1'b0;
      board.set_register(CSR_PHASE_DELAY, {8'd0, delay});
      board.set_register(CSR_START_TIMEOUT, timeout);
   endtask

   // Picks the next word: mostly valid commands on an idle engine and ticks that
   // carry the operation through, with rejected commands and line noise mixed in.
   function automatic item_type pick_word();
      item_type w;
      w.kind    = 1'b0;
      w.command = 3'($urandom_range(0, 7));
      w.wdata   = 8'($urandom_range(0, 255));
      w.sda_in  = 1'($urandom_range(0, 1));
      w.scl_in  = 1'($urandom_range(0, 1));
      if (board.op_code == OP_IDLE) begin
         if ($urandom_range(0, 99) < 80) begin
            w.kind = 1'b1;
            if ($urandom_range(0, 99) < 94)
               w.command = 3'($urandom_range(CMD_START, CMD_READ_NACK));
            // Some starts see a busy bus for a while, at times long enough to time out.
            if (w.command == CMD_START)
               busy_ticks_left = ($urandom_range(0, 99) < 40) ? $urandom_range(1, 16) : 0;
         end
      end else if ($urandom_range(0, 99) < 3) begin
         w.kind = 1'b1;
      end else if (board.op_code == CMD_START && board.phase == 0) begin
         if (busy_ticks_left > 0) begin
            busy_ticks_left--;
            if (w.sda_in && w.scl_in) begin
               if ($urandom_range(0, 1)) w.sda_in = 1'b0;
               else w.scl_in = 1'b0;
            end
         end else begin
            w.sda_in = 1'b1;
            w.scl_in = 1'b1;
         end
      end else begin
         w.scl_in = ($urandom_range(0, 9) != 0);
      end
      return w;
   endfunction

   // One configuration setting followed by random traffic under it.
   task automatic run_setting(input logic [7:0] delay, input logic [15:0] timeout,
                              input int unsigned count, input bit gaps, input bit stalls);
      wait_for_drain();
      write_registers(delay, timeout);
      sender_gaps_on     = gaps;
      receiver_stalls_on = stalls;
      repeat (count) send_word(pick_word());
      finish_running();
   endtask

   // Stimulus: reset, a directed pass over the operations, then random settings.
   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero delay acts as one tick per phase; zero timeout fails on the first busy tick.
      write_registers(8'd0, 16'd0);
      send_tick(1'b0, 1'b0);
      send_command(3'd7, 8'h00);
      send_command(3'd5, 8'hFF);
      send_command(CMD_START, 8'h00);
      send_command(CMD_STOP, 8'hFF);
      send_tick(1'b0, 1'b1);
      send_command(CMD_START, 8'h5A);
      send_tick(1'b1, 1'b1);
      finish_running();
      send_command(CMD_WRITE, 8'hFF);
      finish_running();
      send_command(CMD_READ_ACK, 8'h00);
      finish_running();
      send_command(CMD_READ_NACK, 8'h00);
      finish_running();
      send_command(CMD_STOP, 8'h00);
      finish_running();

      run_setting(8'd1, 16'd5, 250, 1'b1, 1'b1);
      run_setting(8'd2, 16'd0, 200, 1'b0, 1'b1);
      run_setting(8'd3, 16'd12, 200, 1'b1, 1'b0);
      run_setting(8'd20, 16'd65535, 250, 1'b0, 1'b0);
      run_setting(8'd1, 16'd65535, 250, 1'b1, 1'b1);
      run_setting(PHASE_DELAY_RESET, START_TIMEOUT_RESET, 150, 1'b0, 1'b0);
      run_setting(8'd0, 16'd3, 150, 1'b1, 1'b1);

      wait_for_drain();
      repeat (6) @(posedge clock);
      if (board.error_count == 0) begin
         $display("i2c_master_byte_engine_core_tb: done, clean");
      end else begin
         $display("i2c_master_byte_engine_core_tb: done, errors");
      end
      $finish;
   end

   // Result side: random stalls, one long hold-off so the block backs up, and a
   // check of every accepted result word.
   initial begin : receiver
      result_type  got;
      int unsigned stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!long_hold_done && board.checked_count >= 300) begin
            long_hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            stall = receiver_stalls_on ? pick_gap() : 0;
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            @(posedge clock);
            while (!rsp_valid) @(posedge clock);
            got.scl_out   = rsp_scl_out;
            got.sda_out   = rsp_sda_out;
            got.done_res  = rsp_done_res;
            got.status    = rsp_status;
            got.rdata     = rsp_rdata;
            got.ready_res = rsp_ready_res;
            board.check_word(got);
         end
      end
   end

   // Watchdog: ends the run when no word moves on either side for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("i2c_master_byte_engine_core_tb: done, errors");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

endmodule

/* files.f */
+incdir+rtl
rtl/i2cmbe_pkg.sv
rtl/i2cmbe_engine.sv
rtl/i2c_master_byte_engine_core.sv
rtl/i2cmbe_checker.sv
dv/i2c_master_byte_engine_core_tb.sv
